FILE: sv/ed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed_pkg
// Shared types and constants for the edit distance core.
// ----------------------------------------------------------------------------
package ed_pkg;

  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;
  localparam int GAP_W  = 4;
  localparam int DIST_W = 11;

  localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH   = 2'd2;

  localparam logic [GAP_W-1:0]  GAP_RESET = 4'd2;
  localparam logic [DIST_W-1:0] DIST_MAX  = 11'd2047;

  // token kind moving down the cell chain
  typedef struct packed {
    logic row;  // one row of the first string
    logic fin;  // end marker, collects the result
  } ctl_t;

endpackage

FILE: sv/ed_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed_cell
// One column of the cost table: holds one symbol of the second string and
// the latest cost of its column, updates it as each row token passes.
// ----------------------------------------------------------------------------
module ed_cell #(
  parameter int J  = 1,
  parameter int DW = 11,
  parameter int LW = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ed_pkg::GAP_W-1:0]  gap_i,
  input  logic                      init_i,
  input  logic [LW-1:0]             m_len_i,
  input  logic                      b_we_i,
  input  logic [LW-1:0]             b_idx_i,
  input  logic [ed_pkg::SYM_W-1:0]  b_sym_i,
  input  ed_pkg::ctl_t              ctl_i,
  input  logic [ed_pkg::SYM_W-1:0]  sym_i,
  input  logic [DW-1:0]             left_i,
  input  logic [DW-1:0]             diag_i,
  input  logic [DW-1:0]             res_i,
  output ed_pkg::ctl_t              ctl_o,
  output logic [ed_pkg::SYM_W-1:0]  sym_o,
  output logic [DW-1:0]             left_o,
  output logic [DW-1:0]             diag_o,
  output logic [DW-1:0]             res_o
);
  import ed_pkg::*;

  logic [SYM_W-1:0] b_q;
  logic [DW-1:0]    d_q;
  logic [DW-1:0]    gap_ext;
  logic [DW-1:0]    c_up;
  logic [DW-1:0]    c_left;
  logic [DW-1:0]    c_diag;
  logic [DW-1:0]    c_min;
  logic [DW-1:0]    new_d;
  logic             is_last;

  assign gap_ext = DW'(gap_i);
  assign c_up    = d_q + gap_ext;
  assign c_left  = left_i + gap_ext;
  assign c_diag  = diag_i + DW'(sym_i != b_q);
  assign c_min   = (c_up <= c_left) ? c_up : c_left;
  assign new_d   = (c_min <= c_diag) ? c_min : c_diag;
  assign is_last = (m_len_i == LW'(J));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_we_i && (b_idx_i == LW'(J - 1))) begin
      b_q <= b_sym_i;
    end
    if (init_i) begin
      d_q <= DW'(J) * gap_ext;  // top row: J gaps
    end else if (ctl_i.row) begin
      d_q <= new_d;
    end
    sym_o  <= sym_i;
    left_o <= new_d;
    diag_o <= d_q;
    // the end marker picks up the cost of the last column on its way
    res_o  <= (ctl_i.fin && is_last) ? d_q : res_i;
  end

endmodule

FILE: sv/ed_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed_seq
// Request handling, string loading and row sequencer: stores the first
// string, steers second-string symbols to the cells, and feeds one row token
// per cycle into the cell chain followed by an end marker.
// ----------------------------------------------------------------------------
module ed_seq #(
  parameter int MAX_LEN = 64,
  parameter int DW      = 11,
  parameter int LW      = 7,
  parameter int AW      = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  output logic                      s_ready_o,
  input  logic [ed_pkg::OP_W-1:0]   op_i,
  input  logic [ed_pkg::SYM_W-1:0]  sym_i,
  input  logic [ed_pkg::GAP_W-1:0]  gap_i,
  input  logic                      out_busy_i,
  input  logic                      done_i,
  output logic                      init_o,
  output logic [LW-1:0]             m_len_o,
  output logic                      b_we_o,
  output logic [LW-1:0]             b_idx_o,
  output logic [ed_pkg::SYM_W-1:0]  b_sym_o,
  output logic                      ovf_o,
  output ed_pkg::ctl_t              ctl_o,
  output logic [ed_pkg::SYM_W-1:0]  sym_o,
  output logic [DW-1:0]             left_o,
  output logic [DW-1:0]             diag_o,
  output logic [DW-1:0]             res_o
);
  import ed_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;

  logic [2:0]       state_q;
  logic [LW-1:0]    len_a_q, len_b_q, n_q, m_q, i_q;
  logic [LW-1:0]    i_inc;
  logic             ovf_q, ovf_cap_q;
  logic [DW-1:0]    acc_q;
  logic [SYM_W-1:0] a_mem [MAX_LEN];
  logic [SYM_W-1:0] rd_q;
  logic [AW-1:0]    rd_addr;
  logic             accept, a_full, b_full, a_we, row_go;

  assign s_ready_o = (state_q == S_IDLE) && !out_busy_i;
  assign accept    = s_valid_i && s_ready_o;
  assign a_full    = (len_a_q == LW'(MAX_LEN));
  assign b_full    = (len_b_q == LW'(MAX_LEN));
  assign a_we      = accept && (op_i == OP_APPEND_A) && !a_full;
  assign b_we_o    = accept && (op_i == OP_APPEND_B) && !b_full;
  assign b_idx_o   = len_b_q;
  assign b_sym_o   = sym_i;
  assign init_o    = (state_q == S_INIT);
  assign m_len_o   = m_q;
  assign ovf_o     = ovf_cap_q;
  assign row_go    = (state_q == S_RUN) && (i_q != n_q);
  assign i_inc     = i_q + 1'b1;
  // prefetch the symbol of the next row
  assign rd_addr   = (state_q == S_RUN) ? i_inc[AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[len_a_q[AW-1:0]] <= sym_i;
    end
    rd_q <= a_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_a_q   <= '0;
      len_b_q   <= '0;
      n_q       <= '0;
      m_q       <= '0;
      i_q       <= '0;
      ovf_q     <= 1'b0;
      ovf_cap_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (op_i)
              OP_APPEND_A: begin
                if (a_full) ovf_q <= 1'b1;
                else        len_a_q <= len_a_q + 1'b1;
              end
              OP_APPEND_B: begin
                if (b_full) ovf_q <= 1'b1;
                else        len_b_q <= len_b_q + 1'b1;
              end
              OP_FINISH: begin
                n_q       <= len_a_q;
                m_q       <= len_b_q;
                len_a_q   <= '0;
                len_b_q   <= '0;
                ovf_cap_q <= ovf_q;
                ovf_q     <= 1'b0;
                i_q       <= '0;
                state_q   <= S_INIT;
              end
              default: ;
            endcase
          end
        end
        S_INIT: begin
          state_q <= S_RUN;
        end
        S_RUN: begin
          if (row_go) begin
            i_q <= i_inc;
          end else begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (done_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // one row token per cycle, then the end marker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= '{row: row_go, fin: (state_q == S_RUN) && !row_go};
    end
  end

  // acc_q holds i*gap for the row about to be issued
  always_ff @(posedge clk_i) begin
    if (state_q == S_INIT) begin
      acc_q <= '0;
    end else if (row_go) begin
      acc_q <= acc_q + DW'(gap_i);
    end
    sym_o  <= rd_q;
    left_o <= acc_q + DW'(gap_i);
    diag_o <= acc_q;
    res_o  <= acc_q;  // cost when the second string is empty
  end

endmodule

FILE: sv/edit_distance_dp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_dp_core
// Global alignment cost of two byte strings on a systolic column array.
// ----------------------------------------------------------------------------
// Symbol loads (tuser 0: first string, 1: second string) are taken one per
// cycle. A finish request (tuser 2) runs the cost table as a wavefront: each
// of the MAX_LEN cells owns one column, row tokens enter one per cycle and an
// end marker follows; the result is taken from the end marker as it leaves
// the last cell of the full chain. No request is taken while a finish is in
// progress or while a result waits on the output. Symbols past MAX_LEN are
// dropped and flagged; tuser 3 is ignored.
module edit_distance_dp_core #(
  parameter int MAX_LEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        gap_we_i,
  input  logic [3:0]  gap_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [10:0] distance, [11] overflow
);
  import ed_pkg::*;

  localparam int DW = $clog2(2 * MAX_LEN * 15 + 2);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = (DW > DIST_W) ? DW : DIST_W;

  logic [GAP_W-1:0]  gap_q;
  logic              init, b_we, ovf, out_busy, done;
  logic [LW-1:0]     m_len, b_idx;
  logic [SYM_W-1:0]  b_sym;
  ctl_t              ctl  [MAX_LEN+1];
  logic [SYM_W-1:0]  sym  [MAX_LEN+1];
  logic [DW-1:0]     left [MAX_LEN+1];
  logic [DW-1:0]     diag [MAX_LEN+1];
  logic [DW-1:0]     res  [MAX_LEN+1];
  logic [CW-1:0]     res_w;
  logic [DIST_W-1:0] dist_sat;
  logic [DIST_W-1:0] dist_q;
  logic              ovf_q;
  logic              m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= GAP_RESET;
    end else if (gap_we_i) begin
      gap_q <= gap_wdata_i;
    end
  end

  assign out_busy = m_valid_q && !m_axis_tready;
  assign done     = ctl[MAX_LEN].fin;

  ed_seq #(
    .MAX_LEN (MAX_LEN),
    .DW      (DW),
    .LW      (LW),
    .AW      (AW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .op_i       (s_axis_tuser),
    .sym_i      (s_axis_tdata),
    .gap_i      (gap_q),
    .out_busy_i (out_busy),
    .done_i     (done),
    .init_o     (init),
    .m_len_o    (m_len),
    .b_we_o     (b_we),
    .b_idx_o    (b_idx),
    .b_sym_o    (b_sym),
    .ovf_o      (ovf),
    .ctl_o      (ctl[0]),
    .sym_o      (sym[0]),
    .left_o     (left[0]),
    .diag_o     (diag[0]),
    .res_o      (res[0])
  );

  for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
    ed_cell #(
      .J  (k),
      .DW (DW),
      .LW (LW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .gap_i   (gap_q),
      .init_i  (init),
      .m_len_i (m_len),
      .b_we_i  (b_we),
      .b_idx_i (b_idx),
      .b_sym_i (b_sym),
      .ctl_i   (ctl[k-1]),
      .sym_i   (sym[k-1]),
      .left_i  (left[k-1]),
      .diag_i  (diag[k-1]),
      .res_i   (res[k-1]),
      .ctl_o   (ctl[k]),
      .sym_o   (sym[k]),
      .left_o  (left[k]),
      .diag_o  (diag[k]),
      .res_o   (res[k])
    );
  end

  assign res_w    = CW'(res[MAX_LEN]);
  assign dist_sat = (res_w > CW'(DIST_MAX)) ? DIST_MAX : res_w[DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      dist_q <= dist_sat;
      ovf_q  <= ovf;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, ovf_q, dist_q};

  // no request while a result is stuck on the output
  a_ready_vs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !out_busy)
    else $error("input ready while output stalled");

  // end marker must never find an untaken result
  a_done_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !out_busy)
    else $error("result overwritten before it was taken");

  a_valid_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(done))
    else $error("output valid without end marker");

  a_tok_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl[MAX_LEN].row && ctl[MAX_LEN].fin))
    else $error("token is both row and end marker");

endmodule
